### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/qsep_pkg.sv
// ---------------------------------------------------------------------------
// qsep_pkg
// Types and fixed constants of the quartile spread epsilon update unit.
// ---------------------------------------------------------------------------
package qsep_pkg;

   localparam int VALUE_W = 32;
   localparam int OBJ_W   = 3;
   localparam int POP_W   = 9;
   localparam int MULT_W  = 32;
   localparam int EPS_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Product is Q24.40; epsilon is Q16.16, so 24 fraction bits are dropped.
   localparam int PROD_W     = VALUE_W + MULT_W;
   localparam int PROD_SHIFT = 24;

   localparam logic [POP_W-1:0]  POP_SIZE_RESET   = 9'd100;
   localparam logic [MULT_W-1:0] MULTIPLIER_RESET = 32'd1678;
   localparam logic [EPS_W-1:0]  EPSILON_RESET    = 32'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_POP_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_ONLY = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] objective_value;
      logic [OBJ_W-1:0]          objective_index;
   } req_word_type;

   typedef struct packed {
      logic [OBJ_W-1:0] result_objective;
      logic [EPS_W-1:0] epsilon_out;
      logic             applied;
   } rsp_word_type;

   // Command to the sorted chain: insert a new value, or move every
   // entry one place toward the head.
   typedef struct packed {
      logic insert;
      logic shift;
   } chain_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SHIFT,
      ST_MULT,
      ST_FINISH
   } state_type;

endpackage

### sv/quartile_spread_epsilon_update_unit.sv
// ---------------------------------------------------------------------------
// quartile_spread_epsilon_update_unit
// First-quartile spread of a run of objective values, scaled into an epsilon.
// ---------------------------------------------------------------------------
// Input words carry one signed Q16.16 objective value and an objective index.
// Every word of a run goes into a sorted chain of cells in a single cycle, so
// within a run the block takes one word per cycle. The word that completes a
// run (pop_size words) starts the evaluation: the head of the chain is kept as
// the minimum, then the chain moves toward its head k = pop_size/4 times so
// that the k-th smallest value reaches the head, the spread is multiplied by
// the Q8.24 multiplier, and the stored epsilon of the objective is updated.
// The input is stalled while the evaluation runs through the load, shift,
// multiply and finish states; the finish state loads the result word. Other
// words produce no result.
// The result sits in an output register; while the receiver stalls it holds
// its word, and the next run still streams in. Only a second run end waits.
// Reset clears the run count, the register file (pop_size 100, multiplier
// 1678, lower-only flag 0) and marks every stored epsilon as its reset value 7.
// Register writes take effect at once and need no handshake.
// ---------------------------------------------------------------------------
module quartile_spread_epsilon_update_unit #(
   parameter int MAX_POPULATION = 256,
   parameter int MAX_OBJECTIVES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  qsep_pkg::req_word_type               req_word,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output qsep_pkg::rsp_word_type               rsp_word,
   // Register write port.
   input  logic                                 csr_write_en,
   input  logic [qsep_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qsep_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import qsep_pkg::*;

   // The chain keeps one entry more than a quarter of the largest run.
   localparam int DEPTH   = MAX_POPULATION / 4 + 1;
   localparam int COUNT_W = $clog2(MAX_POPULATION + 1);
   localparam int SHIFT_W = $clog2(DEPTH);
   localparam int TAB_AW  = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;

   // Register file.
   logic [POP_W-1:0]  pop_size_ff;
   logic [MULT_W-1:0] multiplier_ff;
   logic              lower_only_ff;

   // Control.
   state_type            state_ff;
   state_type            state_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [SHIFT_W-1:0]   shift_cnt_ff;

   // Datapath.
   logic [OBJ_W-1:0]          obj_ff;
   logic signed [VALUE_W-1:0] min_ff;
   logic [VALUE_W-1:0]        diff_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [PROD_W-1:0]         prod_in;
   logic signed [VALUE_W-1:0] head_value;
   logic [EPS_W-1:0]          stored_eps;
   logic [EPS_W-1:0]          eps_w;
   logic                      in_range;
   logic                      applied_w;

   logic                      rsp_valid_ff;
   rsp_word_type              rsp_word_ff;

   logic [31:0]               run_len_wide;
   logic [COUNT_W-1:0]        run_len;
   logic [SHIFT_W-1:0]        quartile_idx;
   logic                      accept;
   logic                      run_end;
   logic                      out_free;
   logic                      out_load;
   chain_cmd_type             cmd;

   // Helpers for the checks at the end of the module.
   logic                      in_finish;
   logic                      rsp_obj_ok;

   // -------------------------------------------------------------------
   // Register writes. An index past the last register is ignored.
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pop_size_ff   <= POP_SIZE_RESET;
         multiplier_ff <= MULTIPLIER_RESET;
         lower_only_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_POP_SIZE:   pop_size_ff   <= csr_wdata[POP_W-1:0];
            CSR_MULTIPLIER: multiplier_ff <= csr_wdata[MULT_W-1:0];
            CSR_LOWER_ONLY: lower_only_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------------------
   // Run length: a zero pop_size means one, and it is capped at the
   // largest population the chain is built for.
   // -------------------------------------------------------------------
   always_comb begin
      priority if (pop_size_ff == '0) begin
         run_len_wide = 32'd1;
      end else if (32'(pop_size_ff) > 32'(MAX_POPULATION)) begin
         run_len_wide = 32'(MAX_POPULATION);
      end else begin
         run_len_wide = 32'(pop_size_ff);
      end
   end

   assign run_len      = run_len_wide[COUNT_W-1:0];
   assign quartile_idx = SHIFT_W'(run_len >> 2);

   assign accept   = req_valid && !req_stall;
   // The current pop_size decides the end, even if it changed mid run.
   assign count_in = COUNT_W'(count_ff + 1'b1);
   assign run_end  = count_in >= run_len;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // -------------------------------------------------------------------
   // Sequencer: next state.
   // -------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && run_end) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (shift_cnt_ff == '0) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------
   // Sequencer: outputs.
   // -------------------------------------------------------------------
   always_comb begin
      req_stall  = 1'b1;
      cmd.insert = 1'b0;
      cmd.shift  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.insert = req_valid;
         end
         ST_LOAD: begin
         end
         ST_SHIFT: begin
            cmd.shift = shift_cnt_ff != '0;
         end
         ST_MULT: begin
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff <= run_end ? '0 : count_in;
         end
      end
   end

   // -------------------------------------------------------------------
   // Sorted chain. The fill count tells each cell whether it holds a
   // value of the current run.
   // -------------------------------------------------------------------
   qsep_chain #(
      .DEPTH   (DEPTH),
      .COUNT_W (COUNT_W)
   ) u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .new_value  (req_word.objective_value),
      .fill_count (count_ff),
      .head_value (head_value)
   );

   // -------------------------------------------------------------------
   // Evaluation datapath. The head is the minimum on entry to the load
   // state; after k moves toward the head it is the k-th smallest value.
   // The spread is never negative, so a 32-bit difference is exact.
   // -------------------------------------------------------------------
   assign prod_in = diff_ff * multiplier_ff;

   always_ff @(posedge clock) begin
      if (accept && run_end) begin
         obj_ff <= req_word.objective_index;
      end
      if (state_ff == ST_LOAD) begin
         min_ff       <= head_value;
         shift_cnt_ff <= quartile_idx;
      end else if (cmd.shift) begin
         shift_cnt_ff <= shift_cnt_ff - 1'b1;
      end
      if (state_ff == ST_SHIFT && shift_cnt_ff == '0) begin
         diff_ff <= $unsigned(head_value) - $unsigned(min_ff);
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= prod_in;
      end
   end

   // Saturate the Q16.16 result when the product has bits above it.
   assign eps_w = (prod_ff[PROD_W-1:PROD_SHIFT+EPS_W] != '0) ? '1
                : prod_ff[PROD_SHIFT+EPS_W-1:PROD_SHIFT];

   assign in_range  = 32'(obj_ff) < 32'(MAX_OBJECTIVES);
   assign applied_w = in_range && (!lower_only_ff || (eps_w < stored_eps));

   // The table is read every cycle at the run's objective; the registered
   // read data is ready by the finish state.
   qsep_eps_table #(
      .DEPTH  (MAX_OBJECTIVES),
      .ADDR_W (TAB_AW)
   ) u_eps_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (TAB_AW'(obj_ff)),
      .rd_value (stored_eps),
      .wr_en    (out_load && applied_w),
      .wr_addr  (TAB_AW'(obj_ff)),
      .wr_data  (eps_w)
   );

   // -------------------------------------------------------------------
   // Output register.
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff.result_objective <= obj_ff;
         rsp_word_ff.epsilon_out      <= eps_w;
         rsp_word_ff.applied          <= applied_w;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // -------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------
   assign in_finish  = state_ff == ST_FINISH;
   assign rsp_obj_ok = 32'(rsp_word_ff.result_objective) < 32'(MAX_OBJECTIVES);

`include "assert_macros.svh"

   `ASSERT_NEXT(a_run_end_starts_eval, accept && run_end, state_ff == ST_LOAD && count_ff == '0)
   `ASSERT_IMPLIES(a_result_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))
   `ASSERT_IMPLIES(a_applied_in_range, rsp_valid_ff && rsp_word_ff.applied, rsp_obj_ok)
   `ASSERT_NEXT(a_finish_waits, in_finish && !out_free, in_finish && $stable(rsp_word_ff))

endmodule

### sv/qsep_cell.sv
// ---------------------------------------------------------------------------
// qsep_cell
// One entry of the sorted insertion chain.
// ---------------------------------------------------------------------------
module qsep_cell (
   input  logic                                clock,
   input  qsep_pkg::chain_cmd_type             cmd,
   input  logic signed [qsep_pkg::VALUE_W-1:0] new_value,
   input  logic                                occupied,
   input  logic                                left_le,
   input  logic signed [qsep_pkg::VALUE_W-1:0] left_value,
   input  logic signed [qsep_pkg::VALUE_W-1:0] right_value,
   output logic signed [qsep_pkg::VALUE_W-1:0] value_out,
   output logic                                le_out
);
   import qsep_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // An occupied entry that is not above the new value stays in place;
   // ties therefore keep their arrival order.
   assign le_out    = occupied && (value_ff <= new_value);
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (le_out) begin
            value_in = value_ff;
         end else if (left_le) begin
            value_in = new_value;
         end else begin
            value_in = left_value;
         end
      end else if (cmd.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### sv/qsep_chain.sv
// ---------------------------------------------------------------------------
// qsep_chain
// Row of sorted cells holding the smallest values of the current run.
// ---------------------------------------------------------------------------
module qsep_chain #(
   parameter int DEPTH   = 65,
   parameter int COUNT_W = 9
) (
   input  logic                                clock,
   input  qsep_pkg::chain_cmd_type             cmd,
   input  logic signed [qsep_pkg::VALUE_W-1:0] new_value,
   input  logic [COUNT_W-1:0]                  fill_count,
   output logic signed [qsep_pkg::VALUE_W-1:0] head_value
);
   import qsep_pkg::*;

   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic signed [VALUE_W-1:0] left_value [DEPTH];
   logic signed [VALUE_W-1:0] right_value [DEPTH];
   logic                      left_le [DEPTH];
   logic                      cell_le [DEPTH];
   logic                      occupied [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         // Entries at or past the fill count hold nothing of this run.
         assign occupied[i] = 32'(fill_count) > 32'(i);

         if (i == 0) begin : g_head
            assign left_le[i]    = 1'b1;
            assign left_value[i] = new_value;
         end else begin : g_body
            assign left_le[i]    = cell_le[i-1];
            assign left_value[i] = cell_value[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_value[i] = cell_value[i];
            qsep_cell u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .new_value   (new_value),
               .occupied    (occupied[i]),
               .left_le     (left_le[i]),
               .left_value  (left_value[i]),
               .right_value (right_value[i]),
               .value_out   (cell_value[i]),
               .le_out      (cell_le[i])
            );
         end else begin : g_inner
            assign right_value[i] = cell_value[i+1];
            qsep_cell u_cell (
               .clock       (clock),
               .cmd         (cmd),
               .new_value   (new_value),
               .occupied    (occupied[i]),
               .left_le     (left_le[i]),
               .left_value  (left_value[i]),
               .right_value (right_value[i]),
               .value_out   (cell_value[i]),
               .le_out      (cell_le[i])
            );
         end
      end
   endgenerate

   assign head_value = cell_value[0];

endmodule

### sv/qsep_eps_table.sv
// ---------------------------------------------------------------------------
// qsep_eps_table
// Stored epsilon per objective, with a valid bit per entry for reset.
// ---------------------------------------------------------------------------
module qsep_eps_table #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [qsep_pkg::EPS_W-1:0]       rd_value,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [qsep_pkg::EPS_W-1:0]       wr_data
);
   import qsep_pkg::*;

   logic [EPS_W-1:0] mem [DEPTH];
   logic             valid_ff [DEPTH];
   logic [EPS_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // An entry never written since reset reads as the reset epsilon.
   assign rd_value = rd_valid_ff ? rd_data_ff : EPSILON_RESET;

endmodule

### tb/quartile_spread_epsilon_update_unit_tb.sv
// ---------------------------------------------------------------------------
// quartile_spread_epsilon_update_unit_tb
// Self-checking testbench for the quartile spread epsilon update unit.
// ---------------------------------------------------------------------------
// Runs of objective values go into the unit. A model inside the testbench
// keeps its own sorted list of the smallest values, the run count, the
// register file and the epsilon table. It works out the expected result word
// for every accepted word that ends a run. A short directed part covers the
// value extremes, the pop size corner cases, saturation, ties and the
// lower-only rule. Random phases follow, each with its own register
// settings. The sender and the receiver both idle at random.
// ---------------------------------------------------------------------------
module quartile_spread_epsilon_update_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qsep_pkg::*;

   localparam int MAX_POP   = 256;
   localparam int MAX_OBJ   = 8;
   // Depth of the sorted list: enough for the entry at index pop_size/4.
   localparam int CHAIN_LEN = MAX_POP / 4 + 1;
   // The unit answers a run end after k shifts of its chain, k at most MAX_POP/4.
   localparam int SETTLE_CYCLES = MAX_POP / 4 + 16;
   // Stimulus stops once about this many words have been queued.
   localparam int WORD_TARGET = 920;
   // Register index past the last register; a write there changes nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   req_word_type          req_word     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   // Words waiting to be sent, and the result words that the model expects.
   req_word_type value_backlog[$];
   rsp_word_type expected_updates[$];
   int unsigned  words_queued = 0;
   int unsigned  words_taken  = 0;
   int unsigned  error_count  = 0;
   // While set, neither side idles.
   bit           quiet        = 1'b0;

   // Model state: the register file, the sorted list of the smallest values
   // of the current run, the run count and the stored epsilon per objective.
   logic [POP_W-1:0]    pop_reg;
   logic [MULT_W-1:0]   mult_reg;
   logic                dec_reg;
   logic signed [31:0]  sorted_low [CHAIN_LEN];
   int unsigned         run_count;
   logic [EPS_W-1:0]    eps_store [MAX_OBJ];

   quartile_spread_epsilon_update_unit #(
      .MAX_POPULATION(MAX_POP),
      .MAX_OBJECTIVES(MAX_OBJ)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic flag_mismatch(input string what);
      if (error_count < 100) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Takes one accepted word into the model. The word is placed into the
   // sorted list, which keeps ties in arrival order and drops whatever falls
   // off its end. When the word completes a run, the spread between the
   // entry at pop_size/4 and the minimum is scaled by the Q8.24 multiplier,
   // saturated to 32 bits, and in lower-only mode compared with the stored epsilon.
   function automatic void absorb_value(input req_word_type w);
      logic signed [31:0] v;
      logic signed [32:0] spread;
      logic [63:0]        scaled;
      logic [EPS_W-1:0]   eps;
      int unsigned        n, held, p, i, k;
      rsp_word_type       r;
      v = w.objective_value;
      n = (pop_reg == 0) ? 1 : ((pop_reg > MAX_POP) ? MAX_POP : pop_reg);
      held = (run_count < CHAIN_LEN) ? run_count : CHAIN_LEN;
      p = 0;
      while (p < held && sorted_low[p] <= v) begin
         p++;
      end
      if (p < CHAIN_LEN) begin
         if (held == CHAIN_LEN) begin
            held = CHAIN_LEN - 1;
         end
         for (i = held; i > p; i--) begin
            sorted_low[i] = sorted_low[i-1];
         end
         sorted_low[p] = v;
      end
      run_count++;
      if (run_count < n) begin
         return;
      end
      run_count = 0;
      k = n / 4;
      // Never negative, and at most 2^32 - 1, so the low 32 bits hold it.
      spread = sorted_low[k] - sorted_low[0];
      scaled = ({32'd0, spread[31:0]} * {32'd0, mult_reg}) >> PROD_SHIFT;
      eps = (scaled[63:32] != 0) ? '1 : scaled[31:0];
      r.result_objective = w.objective_index;
      r.epsilon_out      = eps;
      r.applied          = 1'b0;
      if (!dec_reg || eps < eps_store[w.objective_index]) begin
         eps_store[w.objective_index] = eps;
         r.applied = 1'b1;
      end
      expected_updates.push_back(r);
   endfunction

   // The sender. A word stays on the bus until the unit takes it; a new one
   // goes out only when the bus is free or the current word is taken at this
   // edge. Gaps come at random unless the quiet stretch is on.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_value(req_word);
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (value_backlog.size() != 0 && (quiet || $urandom_range(99) >= 29)) begin
               req_valid <= 1'b1;
               req_word  <= value_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The receiver. Every result word taken is checked field by field against
   // the oldest expectation. Stalls come at random unless the quiet stretch
   // is on.
   always @(posedge clock) begin : result_monitor
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               flag_mismatch($sformatf("result word with no update pending: obj %0d eps %h",
                                       rsp_word.result_objective, rsp_word.epsilon_out));
            end else begin
               want = expected_updates.pop_front();
               if (rsp_word.result_objective !== want.result_objective) begin
                  flag_mismatch($sformatf("result_objective %0d, expected %0d",
                                          rsp_word.result_objective,
                                          want.result_objective));
               end
               if (rsp_word.epsilon_out !== want.epsilon_out) begin
                  flag_mismatch($sformatf("epsilon_out %h, expected %h (obj %0d)",
                                          rsp_word.epsilon_out, want.epsilon_out,
                                          want.result_objective));
               end
               if (rsp_word.applied !== want.applied) begin
                  flag_mismatch($sformatf("applied %b, expected %b (obj %0d)",
                                          rsp_word.applied, want.applied,
                                          want.result_objective));
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 29);
      end
   end

   // Writes one register through the write port and mirrors it in the
   // model. Only called while the unit is idle.
   task automatic set_register(input logic [CSR_IDX_W-1:0]  idx,
                               input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_POP_SIZE:   pop_reg  = data[POP_W-1:0];
         CSR_MULTIPLIER: mult_reg = data;
         CSR_LOWER_ONLY: dec_reg  = data[0];
         default: ;
      endcase
   endtask

   task automatic queue_word(input logic [31:0] v, input logic [OBJ_W-1:0] obj);
      req_word_type w;
      w.objective_value = v;
      w.objective_index = obj;
      value_backlog.push_back(w);
      words_queued++;
   endtask

   // Waits until every queued word has been taken and every expected result
   // has come, then lets the unit finish any evaluation.
   task automatic drain();
      while (words_taken != words_queued || expected_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Queues whole runs of n words, then a tail of extra words that leaves a
   // run open across the next register change. Each run has its own flavor:
   // fully random, clustered around a base, mostly duplicates, or extremes.
   task automatic queue_runs(input int unsigned n, input int unsigned runs,
                             input int unsigned extra);
      int unsigned      r, i, length, flavor;
      logic [OBJ_W-1:0] obj;
      logic [31:0]      base, v;
      for (r = 0; r <= runs; r++) begin
         length = (r < runs) ? n : extra;
         obj    = OBJ_W'($urandom());
         flavor = $urandom_range(3);
         base   = $urandom();
         for (i = 0; i < length; i++) begin
            case (flavor)
               0:       v = $urandom();
               1:       v = base + ($urandom_range(4095) << $urandom_range(16));
               2:       v = ($urandom_range(3) == 0) ? $urandom() : base;
               default: v = ($urandom_range(1) == 0) ? extreme_value() : $urandom();
            endcase
            // Now and then the objective changes within a run; the last
            // word of the run names the objective.
            if ($urandom_range(7) == 0) begin
               obj = OBJ_W'($urandom());
            end
            queue_word(v, obj);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned        phase, n, runs, extra, j;
      logic [POP_W-1:0]   pop;
      logic [CSR_DATA_W-1:0] data;

      pop_reg   = POP_SIZE_RESET;
      mult_reg  = MULTIPLIER_RESET;
      dec_reg   = 1'b0;
      run_count = 0;
      for (j = 0; j < MAX_OBJ; j++) begin
         eps_store[j] = EPSILON_RESET;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Runs of one word: the spread is always zero. The values are the
      // extremes of the field.
      set_register(CSR_POP_SIZE, 32'd1);
      set_register(CSR_MULTIPLIER, 32'h0100_0000);
      set_register(CSR_LOWER_ONLY, 32'd0);
      queue_word(32'h8000_0000, 3'd0);
      queue_word(32'h7FFF_FFFF, 3'd7);
      queue_word(32'h0000_0000, 3'd5);
      queue_word(32'hFFFF_FFFF, 3'd2);
      drain();

      // A pop size of zero behaves as one. Upper data bits are ignored.
      data = $urandom();
      data[POP_W-1:0] = '0;
      set_register(CSR_POP_SIZE, data);
      queue_word(32'h0001_2345, 3'd1);
      queue_word(32'hFFFE_8000, 3'd3);
      drain();

      // The widest spread times the largest multiplier saturates. The
      // objective changes on every word, so the last one must be reported.
      set_register(CSR_POP_SIZE, 32'd5);
      set_register(CSR_MULTIPLIER, 32'hFFFF_FFFF);
      queue_word(32'h7FFF_FFFF, 3'd0);
      queue_word(32'h8000_0000, 3'd1);
      queue_word(32'h7FFF_FFFF, 3'd2);
      queue_word(32'h7FFF_FFFF, 3'd3);
      queue_word(32'h7FFF_FFFF, 3'd4);
      drain();

      // A write past the last register must leave everything alone.
      set_register(CSR_SPARE, $urandom());

      // Lower-only on an objective still at its reset epsilon. All equal
      // values give zero, which is below the reset value and is applied.
      // A larger result is refused, and so is an equal one.
      set_register(CSR_POP_SIZE, 32'd4);
      set_register(CSR_MULTIPLIER, 32'h0100_0000);
      set_register(CSR_LOWER_ONLY, 32'hFFFF_FFFF);
      for (j = 0; j < 4; j++) begin
         queue_word(32'h0001_0000, 3'd6);
      end
      queue_word(32'd0, 3'd6);
      queue_word(32'h0001_0000, 3'd6);
      queue_word(32'd100, 3'd6);
      queue_word(32'd200, 3'd6);
      for (j = 0; j < 4; j++) begin
         queue_word(32'hFFFF_FFFB, 3'd6);
      end
      drain();

      // Random phases. Each one waits for the unit to go idle, picks new
      // register values and queues a few runs. Two phases use the largest
      // run, one of them through a pop size above the maximum; one phase
      // runs with no idling on either side.
      phase = 0;
      while (words_queued < WORD_TARGET) begin
         drain();
         quiet = (phase == 3);
         if (phase == 3) begin
            pop = 9'd256;
         end else if (phase == 7) begin
            pop = 9'h1FF;
         end else begin
            case ($urandom_range(9))
               0:       pop = 9'd0;
               1, 2:    pop = POP_W'($urandom_range(1, 4));
               default: pop = POP_W'($urandom_range(1, 24));
            endcase
         end
         data = $urandom();
         data[POP_W-1:0] = pop;
         set_register(CSR_POP_SIZE, data);
         case ($urandom_range(5))
            0:       data = 32'd0;
            1:       data = 32'hFFFF_FFFF;
            2:       data = 32'h0100_0000;
            3:       data = $urandom_range(1 << 26);
            default: data = $urandom();
         endcase
         set_register(CSR_MULTIPLIER, data);
         data = $urandom();
         set_register(CSR_LOWER_ONLY, data);
         if ($urandom_range(5) == 0) begin
            set_register(CSR_SPARE, $urandom());
         end
         n     = (pop == 0) ? 1 : ((pop > MAX_POP) ? MAX_POP : pop);
         runs  = (n >= 64) ? 1 : $urandom_range(1, 4);
         extra = ($urandom_range(2) == 0) ? $urandom_range(1, 5) : 0;
         queue_runs(n, runs, extra);
         phase++;
      end
      drain();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin : watchdog
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
